[rtl/shape_function_frontier_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the shape function frontier block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SHAPE_FUNCTION_FRONTIER_ASSERT_SVH
`define SHAPE_FUNCTION_FRONTIER_ASSERT_SVH

// same-cycle implication
`define SFF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shape_function_frontier: same-cycle check failed");

// next-cycle implication
`define SFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shape_function_frontier: next-cycle check failed");

`endif

[rtl/sff_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_pkg
// Shared constants for the shape function frontier block.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int StateW = 4;

  localparam logic [StateW-1:0] S_IDLE   = 4'd0;
  localparam logic [StateW-1:0] S_SR_RD  = 4'd1;
  localparam logic [StateW-1:0] S_SR_CHK = 4'd2;
  localparam logic [StateW-1:0] S_INS    = 4'd3;
  localparam logic [StateW-1:0] S_SH_RD  = 4'd4;
  localparam logic [StateW-1:0] S_SH_WR  = 4'd5;
  localparam logic [StateW-1:0] S_PR_RD  = 4'd6;
  localparam logic [StateW-1:0] S_PR_CHK = 4'd7;
  localparam logic [StateW-1:0] S_EM_RD  = 4'd8;
  localparam logic [StateW-1:0] S_EM_LD  = 4'd9;

endpackage

[rtl/sff_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_table
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sff_table #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/shape_function_frontier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_function_frontier
// Sorted (width, height) table with Pareto staircase output on the final box.
// ----------------------------------------------------------------------------
// Each box is filed into a table of up to TABLE_DEPTH entries held in one
// single-port-read memory, sorted by ascending width. Filing walks the table
// entry by entry: a search of up to n stored entries, then a shift of the
// entries above the insert point. A final box then prunes the table and
// emits each staircase point, and the emission can stall on the output. One
// box is worked on at a time; the last result may still wait in the output
// register while the next box is accepted.
module shape_function_frontier
  import sff_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int SIZE_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SIZE_BITS-1:0] box_width_i,
  input  logic [SIZE_BITS-1:0] box_height_i,
  input  logic                 final_box_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SIZE_BITS-1:0] shape_width_o,
  output logic [SIZE_BITS-1:0] shape_height_o,
  output logic                 end_of_shape_o,
  output logic                 table_overflow_o
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DW    = 2 * SIZE_BITS;

  logic [StateW-1:0]    state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     kept_q, kept_d;
  logic [SIZE_BITS-1:0] last_h_q, last_h_d;
  logic [SIZE_BITS-1:0] w_q, w_d;
  logic [SIZE_BITS-1:0] h_q, h_d;
  logic                 fin_q, fin_d;

  logic                 out_valid_q, out_valid_d;
  logic [SIZE_BITS-1:0] out_w_q, out_w_d;
  logic [SIZE_BITS-1:0] out_h_q, out_h_d;
  logic                 out_end_q, out_end_d;
  logic                 out_ovf_q, out_ovf_d;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [DW-1:0]        mem_wdata, mem_rdata;
  logic [SIZE_BITS-1:0] rd_w, rd_h;
  logic [StateW-1:0]    after_file;
  logic                 out_load;
  logic                 is_end;
  logic [CNT_W-1:0]     idx_dec;

  sff_table #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (DW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_w       = mem_rdata[DW-1:SIZE_BITS];
  assign rd_h       = mem_rdata[SIZE_BITS-1:0];
  assign after_file = fin_q ? S_PR_RD : S_IDLE;
  assign is_end     = ((idx_q + CNT_W'(1)) == kept_q);
  assign idx_dec    = idx_q - CNT_W'(1);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    kept_d      = kept_q;
    last_h_d    = last_h_q;
    w_d         = w_q;
    h_d         = h_q;
    fin_d       = fin_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = {w_q, h_q};
    mem_re      = 1'b0;
    mem_raddr   = idx_q[AW-1:0];
    out_load    = 1'b0;
    out_w_d     = out_w_q;
    out_h_d     = out_h_q;
    out_end_d   = out_end_q;
    out_ovf_d   = out_ovf_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          w_d     = box_width_i;
          h_d     = box_height_i;
          fin_d   = final_box_i;
          idx_d   = '0;
          state_d = S_SR_RD;
        end
      end
      S_SR_RD: begin
        if (idx_q == cnt_q) begin
          pos_d   = cnt_q;
          state_d = S_INS;
        end else begin
          mem_re  = 1'b1;
          state_d = S_SR_CHK;
        end
      end
      S_SR_CHK: begin
        if (rd_w < w_q) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_SR_RD;
        end else if (rd_w == w_q) begin
          mem_we  = (h_q < rd_h);
          state_d = after_file;
          idx_d   = '0;
          kept_d  = '0;
        end else begin
          pos_d   = idx_q;
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
          ovf_d   = 1'b1;
          state_d = after_file;
          idx_d   = '0;
          kept_d  = '0;
        end else begin
          idx_d   = cnt_q;
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (idx_q == pos_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[AW-1:0];
          cnt_d     = cnt_q + CNT_W'(1);
          state_d   = after_file;
          idx_d     = '0;
          kept_d    = '0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_d     = idx_dec;
        state_d   = S_SH_RD;
      end
      S_PR_RD: begin
        if (idx_q == cnt_q) begin
          idx_d   = '0;
          state_d = S_EM_RD;
        end else begin
          mem_re  = 1'b1;
          state_d = S_PR_CHK;
        end
      end
      S_PR_CHK: begin
        if ((kept_q == '0) || (rd_h < last_h_q)) begin
          mem_we    = 1'b1;
          mem_waddr = kept_q[AW-1:0];
          mem_wdata = mem_rdata;
          last_h_d  = rd_h;
          kept_d    = kept_q + CNT_W'(1);
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_PR_RD;
      end
      S_EM_RD: begin
        mem_re  = 1'b1;
        state_d = S_EM_LD;
      end
      S_EM_LD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load  = 1'b1;
          out_w_d   = rd_w;
          out_h_d   = rd_h;
          out_end_d = is_end;
          out_ovf_d = ovf_q;
          if (is_end) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_EM_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    kept_q    <= kept_d;
    last_h_q  <= last_h_d;
    w_q       <= w_d;
    h_q       <= h_d;
    fin_q     <= fin_d;
    out_w_q   <= out_w_d;
    out_h_q   <= out_h_d;
    out_end_q <= out_end_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign shape_width_o    = out_w_q;
  assign shape_height_o   = out_h_q;
  assign end_of_shape_o   = out_end_q;
  assign table_overflow_o = out_ovf_q;

`include "shape_function_frontier_assert.svh"

  `SFF_ASSERT_NOW(a_wr_in_table, mem_we, CNT_W'(mem_waddr) <= cnt_q)
  `SFF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH))
  `SFF_ASSERT_NEXT(a_clear_on_end, out_load && out_end_d, (cnt_q == '0) && !ovf_q)
  `SFF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule
